/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is held.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/pwbd_pkg.sv */
`timescale 1ns / 1ps

package pwbd_pkg;

  localparam int unsigned ExtraDistanceCmDef = 18;

  localparam logic [15:0] GainPRst     = 16'd2621;
  localparam logic [15:0] GainIRst     = 16'd655;
  localparam logic [15:0] GainDRst     = 16'd655;
  localparam logic [15:0] CmPerTickRst = 16'd1229;
  localparam logic signed [15:0] RatioRst = 16'sd4096;

  localparam logic [25:0] TravelMax   = 26'h3FF_FFFF;
  localparam logic [18:0] LeftNumer   = 19'd409600;
  localparam logic [4:0]  DivLastStep = 5'd18;
  localparam logic signed [7:0] SpeedMax = 8'sd100;
  localparam logic signed [7:0] SpeedMin = -8'sd100;

  typedef enum logic [1:0] {
    PhStop  = 2'd0,
    PhDist  = 2'd1,
    PhWall  = 2'd2,
    PhExtra = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    StIdle,
    StTrav,
    StMulP,
    StMulI,
    StMulD,
    StAcc,
    StRatio,
    StMulSpd,
    StCheck,
    StDiv,
    StLeft,
    StOut
  } state_e;

  typedef enum logic [2:0] {
    RegStopMode  = 3'd0,
    RegTarget    = 3'd1,
    RegSpeed     = 3'd2,
    RegGainP     = 3'd3,
    RegGainI     = 3'd4,
    RegGainD     = 3'd5,
    RegCmPerTick = 3'd6
  } reg_idx_e;

endpackage

/* src/pid_wheel_balance_drive_unit.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Straight-line drive controller: one item per encoder sample period, one result item
// back for each. A run is armed by start_req (distance or wall stop rule from
// stop_mode) and the result gives the left/right motor percent and a finished flag.
// All multiplies go through one 32x17 signed multiplier and the division through one
// restoring divider, driven by a small sequencer, so an item is accepted only while
// the sequencer is idle. A sample with the run stopped goes from idle straight to the
// output state; a running sample takes five multiplier passes plus accumulate and ratio
// update; when the right wheel saturates the left speed needs 409600/|ratio| from the
// 19-step divider. The next item can be taken while the result waits.
module pid_wheel_balance_drive_unit #(
  parameter int unsigned EXTRA_DISTANCE_CM = pwbd_pkg::ExtraDistanceCmDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              start_req_i,
  input  logic [7:0]        left_ticks_i,
  input  logic [7:0]        right_ticks_i,
  input  logic              wall_seen_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [7:0] left_speed_o,
  output logic signed [7:0] right_speed_o,
  output logic              finished_o
);

  localparam logic [25:0] ExtraLimit = 26'(EXTRA_DISTANCE_CM * 4096);

  // configuration
  logic        stop_mode_q;
  logic [9:0]  target_q;
  logic [6:0]  speed_q;
  logic [15:0] gain_p_q, gain_i_q, gain_d_q, cm_per_tick_q;

  logic                 cfg_wr;
  pwbd_pkg::reg_idx_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = pwbd_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_mode_q   <= 1'b0;
      target_q      <= '0;
      speed_q       <= '0;
      gain_p_q      <= pwbd_pkg::GainPRst;
      gain_i_q      <= pwbd_pkg::GainIRst;
      gain_d_q      <= pwbd_pkg::GainDRst;
      cm_per_tick_q <= pwbd_pkg::CmPerTickRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pwbd_pkg::RegStopMode:  stop_mode_q   <= pwdata[0];
        pwbd_pkg::RegTarget:    target_q      <= pwdata[9:0];
        pwbd_pkg::RegSpeed:     speed_q       <= pwdata[6:0];
        pwbd_pkg::RegGainP:     gain_p_q      <= pwdata[15:0];
        pwbd_pkg::RegGainI:     gain_i_q      <= pwdata[15:0];
        pwbd_pkg::RegGainD:     gain_d_q      <= pwdata[15:0];
        pwbd_pkg::RegCmPerTick: cm_per_tick_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pwbd_pkg::RegStopMode:  prdata = {31'b0, stop_mode_q};
      pwbd_pkg::RegTarget:    prdata = {22'b0, target_q};
      pwbd_pkg::RegSpeed:     prdata = {25'b0, speed_q};
      pwbd_pkg::RegGainP:     prdata = {16'b0, gain_p_q};
      pwbd_pkg::RegGainI:     prdata = {16'b0, gain_i_q};
      pwbd_pkg::RegGainD:     prdata = {16'b0, gain_d_q};
      pwbd_pkg::RegCmPerTick: prdata = {16'b0, cm_per_tick_q};
      default:                prdata = '0;
    endcase
  end

  // run state
  pwbd_pkg::state_e state_q, state_d;
  pwbd_pkg::phase_e phase_q, phase_d;
  logic [25:0]        travelled_q, travelled_d;
  logic signed [9:0]  err_q, err_d, perr_q, perr_d;
  logic signed [31:0] sum_q, sum_d;
  logic signed [15:0] ratio_q, ratio_d;
  logic signed [49:0] acc_q, acc_d;
  logic signed [48:0] prod_q;
  logic [7:0]         lt_q, rt_q;
  logic signed [7:0]  left_q, left_d, right_q, right_d;
  logic [15:0]        dvs_q, dvs_d;
  logic [15:0]        rem_q, rem_d;
  logic [18:0]        dq_q, dq_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               out_fin_q;
  logic signed [7:0]  out_left_q, out_right_q;

  logic                in_acc, out_load;
  logic signed [31:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [48:0]  mul_p;

  // sample phase decision
  pwbd_pkg::phase_e ph_start, ph_wall, ph_new;
  logic             clr_run;
  logic [25:0]      trav_eff;

  always_comb begin
    ph_start = start_req_i ? (stop_mode_q ? pwbd_pkg::PhWall : pwbd_pkg::PhDist) : phase_q;
    clr_run  = start_req_i;
    ph_wall  = ph_start;
    if (ph_start == pwbd_pkg::PhWall && wall_seen_i) begin
      ph_wall = pwbd_pkg::PhExtra;
      clr_run = 1'b1;
    end
    trav_eff = clr_run ? '0 : travelled_q;
    ph_new   = ph_wall;
    if (ph_wall == pwbd_pkg::PhDist && trav_eff >= {target_q, 12'b0}) begin
      ph_new = pwbd_pkg::PhStop;
    end else if (ph_wall == pwbd_pkg::PhExtra && trav_eff >= ExtraLimit) begin
      ph_new = pwbd_pkg::PhStop;
    end
  end

  // speed check helpers
  logic signed [23:0] spd_prod;
  logic signed [11:0] right_tr;
  logic [7:0]         half_ticks;
  logic signed [9:0]  derr;
  logic               big_derr;
  logic [16:0]        trial;
  logic               trial_ge;

  assign spd_prod   = prod_q[23:0];
  assign right_tr   = 12'((spd_prod + (spd_prod < 0 ? 24'sd4095 : 24'sd0)) >>> 12);
  assign half_ticks = 8'(({1'b0, lt_q} + {1'b0, rt_q}) >> 1);
  assign derr       = err_q - perr_q;
  assign big_derr   = (derr > 10'sd1) || (derr < -10'sd1);
  assign trial      = {rem_q, dq_q[18]};
  assign trial_ge   = trial >= {1'b0, dvs_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pwbd_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (ph_new == pwbd_pkg::PhStop) ? pwbd_pkg::StOut : pwbd_pkg::StTrav;
        end
      end
      pwbd_pkg::StTrav:   state_d = pwbd_pkg::StMulP;
      pwbd_pkg::StMulP:   state_d = pwbd_pkg::StMulI;
      pwbd_pkg::StMulI:   state_d = pwbd_pkg::StMulD;
      pwbd_pkg::StMulD:   state_d = pwbd_pkg::StAcc;
      pwbd_pkg::StAcc:    state_d = pwbd_pkg::StRatio;
      pwbd_pkg::StRatio:  state_d = pwbd_pkg::StMulSpd;
      pwbd_pkg::StMulSpd: state_d = pwbd_pkg::StCheck;
      pwbd_pkg::StCheck: begin
        if (right_tr > 12'sd100 || right_tr < -12'sd100) begin
          state_d = pwbd_pkg::StDiv;
        end else begin
          state_d = pwbd_pkg::StOut;
        end
      end
      pwbd_pkg::StDiv: begin
        if (cnt_q == pwbd_pkg::DivLastStep) begin
          state_d = pwbd_pkg::StLeft;
        end
      end
      pwbd_pkg::StLeft: state_d = pwbd_pkg::StOut;
      pwbd_pkg::StOut: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = pwbd_pkg::StIdle;
        end
      end
      default: state_d = pwbd_pkg::StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      pwbd_pkg::StIdle: in_ready_o = 1'b1;
      pwbd_pkg::StTrav: begin
        mul_a = $signed({24'b0, half_ticks});
        mul_b = $signed({1'b0, cm_per_tick_q});
      end
      pwbd_pkg::StMulP: begin
        mul_a = 32'(err_q);
        mul_b = $signed({1'b0, gain_p_q});
      end
      pwbd_pkg::StMulI: begin
        mul_a = sum_q;
        mul_b = $signed({1'b0, gain_i_q});
      end
      pwbd_pkg::StMulD: begin
        mul_a = 32'(derr);
        mul_b = $signed({1'b0, gain_d_q});
      end
      pwbd_pkg::StMulSpd: begin
        mul_a = 32'(ratio_q);
        mul_b = $signed({10'b0, speed_q});
      end
      pwbd_pkg::StOut: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;
  assign mul_p  = mul_a * mul_b;

  // datapath
  logic [26:0]        trav_sum;
  logic signed [32:0] sum_ext;
  logic signed [9:0]  err_new;
  logic signed [46:0] ratio_sum;

  assign trav_sum  = {1'b0, travelled_q} + {3'b0, prod_q[23:0]};
  assign err_new   = $signed({2'b0, lt_q}) - $signed({2'b0, rt_q});
  assign sum_ext   = 33'(sum_q) + 33'(err_new);
  assign ratio_sum = 47'(ratio_q) + 47'(acc_q >>> 4);

  always_comb begin
    phase_d     = phase_q;
    travelled_d = travelled_q;
    err_d       = err_q;
    perr_d      = perr_q;
    sum_d       = sum_q;
    ratio_d     = ratio_q;
    acc_d       = acc_q;
    left_d      = left_q;
    right_d     = right_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      pwbd_pkg::StIdle: begin
        if (in_acc) begin
          phase_d = ph_new;
          if (clr_run) begin
            travelled_d = '0;
            err_d       = '0;
            perr_d      = '0;
            sum_d       = '0;
          end
          left_d  = '0;
          right_d = '0;
        end
      end
      pwbd_pkg::StTrav: begin
        perr_d = err_q;
        err_d  = err_new;
        if (sum_ext > 33'sd2147483647) begin
          sum_d = 32'sh7FFF_FFFF;
        end else if (sum_ext < -33'sd2147483648) begin
          sum_d = 32'sh8000_0000;
        end else begin
          sum_d = sum_ext[31:0];
        end
      end
      pwbd_pkg::StMulP: begin
        travelled_d = (trav_sum > {1'b0, pwbd_pkg::TravelMax}) ? pwbd_pkg::TravelMax
                                                              : trav_sum[25:0];
      end
      pwbd_pkg::StMulI: acc_d = 50'(prod_q);
      pwbd_pkg::StMulD: acc_d = acc_q + 50'(prod_q);
      pwbd_pkg::StAcc: begin
        if (big_derr) begin
          acc_d = acc_q - 50'(prod_q);
        end
      end
      pwbd_pkg::StRatio: begin
        if (ratio_sum > 47'sd32767) begin
          ratio_d = 16'sh7FFF;
        end else if (ratio_sum < -47'sd32768) begin
          ratio_d = 16'sh8000;
        end else begin
          ratio_d = ratio_sum[15:0];
        end
      end
      pwbd_pkg::StCheck: begin
        dvs_d = ratio_q[15] ? 16'(-ratio_q) : ratio_q;
        rem_d = '0;
        dq_d  = pwbd_pkg::LeftNumer;
        cnt_d = '0;
        if (right_tr > 12'sd100) begin
          right_d = pwbd_pkg::SpeedMax;
        end else if (right_tr < -12'sd100) begin
          right_d = pwbd_pkg::SpeedMin;
        end else begin
          right_d = right_tr[7:0];
          left_d  = (speed_q > 7'd100) ? pwbd_pkg::SpeedMax : $signed({1'b0, speed_q});
        end
      end
      pwbd_pkg::StDiv: begin
        rem_d = trial_ge ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
        dq_d  = {dq_q[17:0], trial_ge};
        cnt_d = cnt_q + 5'd1;
      end
      pwbd_pkg::StLeft: begin
        left_d = (dq_q > 19'd100) ? pwbd_pkg::SpeedMax : $signed(dq_q[7:0]);
      end
      pwbd_pkg::StOut: begin
        if (out_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwbd_pkg::StIdle;
      phase_q     <= pwbd_pkg::PhStop;
      travelled_q <= '0;
      err_q       <= '0;
      perr_q      <= '0;
      sum_q       <= '0;
      ratio_q     <= pwbd_pkg::RatioRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      travelled_q <= travelled_d;
      err_q       <= err_d;
      perr_q      <= perr_d;
      sum_q       <= sum_d;
      ratio_q     <= ratio_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_p;
    acc_q   <= acc_d;
    left_q  <= left_d;
    right_q <= right_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    dq_q    <= dq_d;
    cnt_q   <= cnt_d;
    if (in_acc) begin
      lt_q <= left_ticks_i;
      rt_q <= right_ticks_i;
    end
    if (out_load) begin
      out_left_q  <= left_q;
      out_right_q <= right_q;
      out_fin_q   <= (phase_q == pwbd_pkg::PhStop);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = out_left_q;
  assign right_speed_o = out_right_q;
  assign finished_o    = out_fin_q;

  `ASSERT_CLKD(a_one_item, in_valid_i && in_ready_o |=> !in_ready_o, "item overlap")
  `ASSERT_CLKD(a_stop_zero, out_valid_o && finished_o |-> left_speed_o == 8'sd0 && right_speed_o == 8'sd0, "stopped speed not zero")
  `ASSERT_CLKD(a_speed_rng, out_valid_o |-> left_speed_o <= 8'sd100 && left_speed_o >= -8'sd100 && right_speed_o <= 8'sd100 && right_speed_o >= -8'sd100, "speed out of range")
  `ASSERT_CLKD(a_div_cnt, state_q == pwbd_pkg::StDiv |-> cnt_q <= pwbd_pkg::DivLastStep, "divider overrun")
  `ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule
